@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, off while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked property that also holds across reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/bcs_pkg.sv @@
// Types and constants for the band CPU selector.
`default_nettype none

package bcs_pkg;

   localparam int CPU_COUNT     = 8;
   localparam int CPU_BITS      = 3;
   localparam int FIELD_BITS    = 16;
   localparam int UTIL_BITS     = 16;
   localparam int LOAD_BITS     = UTIL_BITS + 1;
   localparam int DEPTH_BITS    = 4;
   localparam int REQ_DATA_BITS = 80;
   localparam int RSP_DATA_BITS = 8;
   localparam int QUEUE_DEPTH   = 4;
   localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS     = $clog2(QUEUE_DEPTH + 1);

   // One classified candidate, as passed from front to back.
   typedef struct packed {
      logic                  last;
      logic                  take;
      logic                  idle;
      logic [CPU_BITS-1:0]   cpu;
      logic [DEPTH_BITS-1:0] depth;
      logic [UTIL_BITS-1:0]  wake;
      logic [LOAD_BITS-1:0]  load;
   } cand_type;

   typedef struct packed {
      logic                was_idle;
      logic [CPU_BITS-1:0] cpu;
      logic                found;
   } result_type;

endpackage

`default_nettype wire

@@ hw/rtl/band_cpu_select.sv @@
// The item marked last goes into the queue, is popped by the back end after the items
// queued ahead of it, and its result is registered in the result slot.
// One item per cycle while the queue is not full; the compare against the running best
// in the back end is combinational, and a 4-entry queue absorbs output stalls.
// A scan of N items yields one result; the result register holds it while stalled.
// Reset (synchronous, active high) empties the queue, drops the running best
// and clears the pending result.
`default_nettype none

module band_cpu_select (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // cpu_index[2:0], in_mask[3], capacity[19:4], cpu_wake_util[35:20],
   // task_load[51:36], boosted_util[67:52], is_idle[68], idle_depth[72:69], zeros
   input  wire logic [bcs_pkg::REQ_DATA_BITS-1:0] req_tdata,
   input  wire logic                              req_tlast,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // found[0], chosen_cpu[3:1], chosen_was_idle[4], zeros
   output logic [bcs_pkg::RSP_DATA_BITS-1:0]      rsp_tdata
);

   bcs_pkg::cand_type   front_cand;
   bcs_pkg::cand_type   queue_head;
   bcs_pkg::result_type result;
   logic                queue_full;
   logic                queue_valid;
   logic                queue_pop;

   assign req_tready = !queue_full;

   bcs_front u_front (
      .req_tdata (req_tdata),
      .req_tlast (req_tlast),
      .cand      (front_cand)
   );

   bcs_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (req_tvalid),
      .wr_data  (front_cand),
      .pop      (queue_pop),
      .full     (queue_full),
      .rd_valid (queue_valid),
      .rd_data  (queue_head)
   );

   bcs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cand_valid (queue_valid),
      .cand       (queue_head),
      .cand_pop   (queue_pop),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_data   (result)
   );

   assign rsp_tdata = {(bcs_pkg::RSP_DATA_BITS - 5)'(0), result.was_idle, result.cpu,
                       result.found};

endmodule

`default_nettype wire

@@ hw/rtl/bcs_front.sv @@
// Front end: unpack a candidate, form its projected load and eligibility.
`default_nettype none

module bcs_front (
   input  wire logic [bcs_pkg::REQ_DATA_BITS-1:0] req_tdata,
   input  wire logic                              req_tlast,
   output bcs_pkg::cand_type                      cand
);

   logic [bcs_pkg::CPU_BITS-1:0]   cpu;
   logic                           mask;
   logic [bcs_pkg::FIELD_BITS-1:0] cap_f;
   logic [bcs_pkg::FIELD_BITS-1:0] wake_f;
   logic [bcs_pkg::FIELD_BITS-1:0] task_f;
   logic [bcs_pkg::FIELD_BITS-1:0] boost_f;
   logic [bcs_pkg::UTIL_BITS-1:0]  cap;
   logic [bcs_pkg::UTIL_BITS-1:0]  wake;
   logic [bcs_pkg::UTIL_BITS-1:0]  tutil;
   logic [bcs_pkg::UTIL_BITS-1:0]  boost;
   logic [bcs_pkg::LOAD_BITS-1:0]  sum;
   logic [bcs_pkg::LOAD_BITS-1:0]  load;

   assign cpu     = req_tdata[2:0];
   assign mask    = req_tdata[3];
   assign cap_f   = req_tdata[19:4];
   assign wake_f  = req_tdata[35:20];
   assign task_f  = req_tdata[51:36];
   assign boost_f = req_tdata[67:52];

   // Use the low UTIL_BITS of each field, which here is the whole field.
   assign cap   = cap_f[bcs_pkg::UTIL_BITS-1:0];
   assign wake  = wake_f[bcs_pkg::UTIL_BITS-1:0];
   assign tutil = task_f[bcs_pkg::UTIL_BITS-1:0];
   assign boost = boost_f[bcs_pkg::UTIL_BITS-1:0];

   // One bit wider so the sum never wraps.
   assign sum  = {1'b0, wake} + {1'b0, tutil};
   assign load = (sum < {1'b0, boost}) ? {1'b0, boost} : sum;

   always_comb begin
      cand.last  = req_tlast;
      cand.take  = mask && (int'(cpu) < bcs_pkg::CPU_COUNT) && (load <= {1'b0, cap});
      cand.idle  = req_tdata[68];
      cand.cpu   = cpu;
      cand.depth = req_tdata[72:69];
      cand.wake  = wake;
      cand.load  = load;
   end

endmodule

`default_nettype wire

@@ hw/rtl/bcs_fifo.sv @@
// Short candidate queue between front and back.
`default_nettype none

module bcs_fifo (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  bcs_pkg::cand_type      wr_data,
   input  wire logic              pop,
   output logic                   full,
   output logic                   rd_valid,
   output bcs_pkg::cand_type      rd_data
);

   bcs_pkg::cand_type mem [bcs_pkg::QUEUE_DEPTH];

   logic [bcs_pkg::QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [bcs_pkg::QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [bcs_pkg::QCNT_BITS-1:0] count_ff, count_in;
   logic                          do_push;
   logic                          do_pop;

   localparam logic [bcs_pkg::QPTR_BITS-1:0] PTR_LAST =
      bcs_pkg::QPTR_BITS'(bcs_pkg::QUEUE_DEPTH - 1);

   assign full     = (count_ff == bcs_pkg::QCNT_BITS'(bcs_pkg::QUEUE_DEPTH));
   assign rd_valid = (count_ff != '0);
   assign rd_data  = mem[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && rd_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/bcs_back.sv @@
// Back end: keep the running best idle and busy CPU, emit the choice on last.
`default_nettype none

module bcs_back (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          cand_valid,
   input  bcs_pkg::cand_type  cand,
   output logic               cand_pop,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output bcs_pkg::result_type rsp_data
);

   logic                              have_idle_ff, have_idle_in;
   logic [bcs_pkg::CPU_BITS-1:0]      idle_pick_ff, idle_pick_in;
   logic [bcs_pkg::DEPTH_BITS-1:0]    idle_depth_ff, idle_depth_in;
   logic [bcs_pkg::UTIL_BITS-1:0]     idle_util_ff, idle_util_in;
   logic                              have_busy_ff, have_busy_in;
   logic [bcs_pkg::CPU_BITS-1:0]      busy_cpu_ff, busy_cpu_in;
   logic [bcs_pkg::LOAD_BITS-1:0]     busy_load_ff, busy_load_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   bcs_pkg::result_type               rsp_data_ff, rsp_data_in;
   logic                              idle_better;
   logic                              busy_better;

   // Stall only a last item, and only while the result slot stays full.
   assign cand_pop  = cand_valid && (!cand.last || !rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign idle_better = !have_idle_ff
                     || (cand.depth < idle_depth_ff)
                     || ((cand.depth == idle_depth_ff) && (cand.wake < idle_util_ff));
   assign busy_better = !have_busy_ff || (cand.load < busy_load_ff);

   always_comb begin
      have_idle_in  = have_idle_ff;
      idle_pick_in  = idle_pick_ff;
      idle_depth_in = idle_depth_ff;
      idle_util_in  = idle_util_ff;
      have_busy_in  = have_busy_ff;
      busy_cpu_in   = busy_cpu_ff;
      busy_load_in  = busy_load_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;
      if (cand_pop) begin
         if (cand.take && cand.idle && idle_better) begin
            have_idle_in  = 1'b1;
            idle_pick_in  = cand.cpu;
            idle_depth_in = cand.depth;
            idle_util_in  = cand.wake;
         end
         if (cand.take && !cand.idle && busy_better) begin
            have_busy_in = 1'b1;
            busy_cpu_in  = cand.cpu;
            busy_load_in = cand.load;
         end
         if (cand.last) begin
            // Prefer idle, then busy, else report none; then start a new scan.
            rsp_valid_in = 1'b1;
            if (have_idle_in) begin
               rsp_data_in.found    = 1'b1;
               rsp_data_in.cpu      = idle_pick_in;
               rsp_data_in.was_idle = 1'b1;
            end else if (have_busy_in) begin
               rsp_data_in.found    = 1'b1;
               rsp_data_in.cpu      = busy_cpu_in;
               rsp_data_in.was_idle = 1'b0;
            end else begin
               rsp_data_in.found    = 1'b0;
               rsp_data_in.cpu      = '0;
               rsp_data_in.was_idle = 1'b0;
            end
            have_idle_in = 1'b0;
            have_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      idle_pick_ff  <= idle_pick_in;
      idle_depth_ff <= idle_depth_in;
      idle_util_ff  <= idle_util_in;
      busy_cpu_ff   <= busy_cpu_in;
      busy_load_ff  <= busy_load_in;
      rsp_data_ff   <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_idle_ff <= 1'b0;
         have_busy_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         have_idle_ff <= have_idle_in;
         have_busy_ff <= have_busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/bcs_checker.sv @@
// Port-level checks for the band CPU selector, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module bcs_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_tready,
   input wire logic                              rsp_tvalid,
   input wire logic                              rsp_tready,
   input wire logic [bcs_pkg::RSP_DATA_BITS-1:0] rsp_tdata
);

   // A stalled result holds.
   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "result changed while stalled")

   // No CPU chosen means number and idle flag are zero.
   `ASSERT_CLK(a_none_zero, clock, reset, rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[4:1] == 4'd0, "empty result carries a CPU")

   // Reset drops any pending result and opens the input.
   `ASSERT_ALWAYS(a_reset_rsp, clock, reset |=> !rsp_tvalid, "result pending after reset")
   `ASSERT_ALWAYS(a_reset_req, clock, reset |=> req_tready, "input closed after reset")

endmodule

bind band_cpu_select bcs_checker u_checker (.*);

`default_nettype wire

@@ tb/bcs_checker.sv @@
// Scoreboard for the band CPU selector: folds each candidate into a running best and checks picks.
module bcs_scoreboard (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   input  logic                              req_tready,
   // cpu_index, in_mask, capacity, cpu_wake_util, task_load, boosted_util,
   // is_idle, idle_depth, zeros
   input  logic [bcs_pkg::REQ_DATA_BITS-1:0] req_tdata,
   input  logic                              req_tlast,
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // found, chosen_cpu, chosen_was_idle, zeros
   input  logic [bcs_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   output int                                mismatches,
   output int                                open_picks,
   output int                                idle_picks,
   output int                                busy_picks,
   output int                                empty_picks
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CB = bcs_pkg::CPU_BITS;
   localparam int UB = bcs_pkg::UTIL_BITS;
   localparam int LB = bcs_pkg::LOAD_BITS;
   localparam int DB = bcs_pkg::DEPTH_BITS;

   logic          have_idle;
   logic [CB-1:0] idle_pick;
   logic [DB-1:0] idle_depth_best;
   logic [UB-1:0] idle_wake;
   logic          have_busy;
   logic [CB-1:0] busy_cpu;
   logic [LB-1:0] busy_load;

   bcs_pkg::result_type picks_due[$];

   int fails = 0;
   int n_idle = 0;
   int n_busy = 0;
   int n_empty = 0;

   assign mismatches  = fails;
   assign idle_picks  = n_idle;
   assign busy_picks  = n_busy;
   assign empty_picks = n_empty;

   task automatic clear_best();
      have_idle       = 1'b0;
      idle_pick       = '0;
      idle_depth_best = '0;
      idle_wake       = '0;
      have_busy       = 1'b0;
      busy_cpu        = '0;
      busy_load       = '0;
   endtask

   // Fold one candidate into the running best; close the scan on last.
   task automatic fold_candidate(input logic [bcs_pkg::REQ_DATA_BITS-1:0] d, input logic fin);
      logic [CB-1:0] cpu;
      logic          member;
      logic [UB-1:0] cap;
      logic [UB-1:0] wake;
      logic [UB-1:0] tutil;
      logic [UB-1:0] boost;
      logic          idle;
      logic [DB-1:0] depth;
      logic [LB-1:0] load;
      logic          better;
      bcs_pkg::result_type pick;
      cpu    = d[2:0];
      member = d[3];
      cap    = d[19:4];
      wake   = d[35:20];
      tutil  = d[51:36];
      boost  = d[67:52];
      idle   = d[68];
      depth  = d[72:69];
      load   = {1'b0, wake} + {1'b0, tutil};
      if (load < {1'b0, boost}) load = {1'b0, boost};
      if (member && int'(cpu) < bcs_pkg::CPU_COUNT && load <= {1'b0, cap}) begin
         if (idle) begin
            if (!have_idle) better = 1'b1;
            else if (depth != idle_depth_best) better = depth < idle_depth_best;
            else better = wake < idle_wake;
            if (better) begin
               have_idle       = 1'b1;
               idle_pick       = cpu;
               idle_depth_best = depth;
               idle_wake       = wake;
            end
         end else if (!have_busy || load < busy_load) begin
            have_busy = 1'b1;
            busy_cpu  = cpu;
            busy_load = load;
         end
      end
      if (fin) begin
         pick = '0;
         if (have_idle) begin
            pick.found    = 1'b1;
            pick.cpu      = idle_pick;
            pick.was_idle = 1'b1;
         end else if (have_busy) begin
            pick.found = 1'b1;
            pick.cpu   = busy_cpu;
         end
         picks_due.push_back(pick);
         clear_best();
      end
   endtask

   task automatic check_pick(input logic [bcs_pkg::RSP_DATA_BITS-1:0] d);
      bcs_pkg::result_type want;
      bcs_pkg::result_type got;
      got = d[4:0];
      if (picks_due.size() == 0) begin
         $error("pick with no scan closed: found %0d chosen_cpu %0d chosen_was_idle %0d",
                got.found, got.cpu, got.was_idle);
         fails++;
      end else begin
         want = picks_due.pop_front();
         if (got.found !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, got.found);
            fails++;
         end
         if (got.cpu !== want.cpu) begin
            $error("chosen_cpu: expected %0d, got %0d", want.cpu, got.cpu);
            fails++;
         end
         if (got.was_idle !== want.was_idle) begin
            $error("chosen_was_idle: expected %0d, got %0d", want.was_idle, got.was_idle);
            fails++;
         end
         if (!want.found) n_empty++;
         else if (want.was_idle) n_idle++;
         else n_busy++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_best();
         picks_due.delete();
      end else begin
         // a pick never belongs to a scan closed at the same edge
         if (rsp_tvalid && rsp_tready) check_pick(rsp_tdata);
         if (req_tvalid && req_tready) fold_candidate(req_tdata, req_tlast);
      end
      open_picks <= picks_due.size();
   end

endmodule

@@ tb/tb_top.sv @@
// Top of the band CPU selector testbench: clock, reset, candidate scans and the verdict.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ITEM_TARGET  = 1650;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 20;

   typedef struct packed {
      logic [bcs_pkg::DEPTH_BITS-1:0] depth;
      logic                           idle;
      logic [bcs_pkg::UTIL_BITS-1:0]  boost;
      logic [bcs_pkg::UTIL_BITS-1:0]  tutil;
      logic [bcs_pkg::UTIL_BITS-1:0]  wake;
      logic [bcs_pkg::UTIL_BITS-1:0]  cap;
      logic                           mask;
      logic [bcs_pkg::CPU_BITS-1:0]   cpu;
   } cand_item_type;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_tvalid = 1'b0;
   logic                              req_tready;
   logic [bcs_pkg::REQ_DATA_BITS-1:0] req_tdata = '0;
   logic                              req_tlast = 1'b0;
   logic                              rsp_tvalid;
   logic                              rsp_tready = 1'b0;
   logic [bcs_pkg::RSP_DATA_BITS-1:0] rsp_tdata;

   int mismatches;
   int open_picks;
   int idle_picks;
   int busy_picks;
   int empty_picks;

   int   items_sent = 0;
   int   scans_sent = 0;
   int   cycles = 0;
   bit   steady = 1'b0;
   bit   rsp_hold = 1'b0;
   bit   held_off = 1'b0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   band_cpu_select DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   bcs_scoreboard pick_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .mismatches  (mismatches),
      .open_picks  (open_picks),
      .idle_picks  (idle_picks),
      .busy_picks  (busy_picks),
      .empty_picks (empty_picks)
   );

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("tb_top: errors");
         $finish;
      end
   end

   function automatic cand_item_type make_cand(input int cpu, input bit mask, input int cap,
                                               input int wake, input int tutil,
                                               input int boost, input bit idle,
                                               input int depth);
      cand_item_type c;
      c.cpu   = 3'(cpu);
      c.mask  = mask;
      c.cap   = 16'(cap);
      c.wake  = 16'(wake);
      c.tutil = 16'(tutil);
      c.boost = 16'(boost);
      c.idle  = idle;
      c.depth = 4'(depth);
      return c;
   endfunction

   // Bias capacity around the projected load so both the fit and the skip are common.
   function automatic cand_item_type random_cand(input logic [2:0] cpu, input logic [15:0] tu,
                                                 input logic [15:0] bu);
      cand_item_type c;
      logic [16:0]   load;
      int            pick;
      c.cpu   = cpu;
      c.mask  = ($urandom_range(0, 6) != 0);
      c.tutil = tu;
      c.boost = bu;
      pick = $urandom_range(0, 9);
      if (pick < 4) c.wake = 16'($urandom_range(0, 8) * 64);
      else if (pick < 8) c.wake = 16'($urandom_range(0, 1024));
      else c.wake = 16'($urandom);
      load = {1'b0, c.wake} + {1'b0, tu};
      if (load < {1'b0, bu}) load = {1'b0, bu};
      pick = $urandom_range(0, 19);
      if (pick < 3) c.cap = 16'hFFFF;
      else if (pick < 6) c.cap = load[16] ? 16'hFFFF : load[15:0];
      else if (pick < 8) c.cap = load[16] ? 16'hFFFF : load[15:0] - 16'd1;
      else if (pick < 11) c.cap = 16'($urandom);
      else c.cap = 16'($urandom_range(512, 2048));
      c.idle  = ($urandom_range(0, 4) < 2);
      c.depth = ($urandom_range(0, 4) < 3) ? 4'($urandom_range(0, 2))
                                           : 4'($urandom_range(0, 15));
      return c;
   endfunction

   // Called at a rising edge; returns at the edge where the item is taken.
   task automatic offer(input cand_item_type c, input logic fin);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(bcs_pkg::REQ_DATA_BITS - $bits(cand_item_type)){1'b0}}, c};
      req_tlast  <= fin;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
      if (fin) scans_sent++;
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (open_picks != 0) @(posedge clock);
   endtask

   task automatic random_scan();
      int            mode;
      int            len;
      logic [15:0]   tu;
      logic [15:0]   bu;
      logic [2:0]    cpu;
      logic [95:0]   noise;
      cand_item_type c;
      mode = $urandom_range(0, 9);
      tu = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 600));
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: bu = '0;
         5, 6, 7:       bu = 16'($urandom_range(0, 1200));
         default:       bu = 16'($urandom);
      endcase
      // full sweeps dominate; the rest are short scans, absent bands and noisy ones
      if (mode < 6) len = 8;
      else if (mode == 8) len = $urandom_range(1, 4);
      else len = $urandom_range(1, 12);
      for (int i = 0; i < len; i++) begin
         cpu = (mode < 6) ? 3'(i) : 3'($urandom_range(0, 7));
         c = random_cand(cpu, tu, bu);
         if (mode == 8) c.mask = 1'b0;
         if (mode == 9 && $urandom_range(0, 2) == 0) begin
            noise = {$urandom, $urandom, $urandom};
            c = noise[$bits(cand_item_type)-1:0];
         end
         offer(c, i == len - 1);
      end
   endtask

   initial begin : receiver
      int wait_cycles;
      while (reset) @(posedge clock);
      forever begin
         if (rsp_hold) begin
            rsp_hold = 1'b0;
            wait_cycles = HOLD_CYCLES;
         end else begin
            wait_cycles = steady ? 0 : $urandom_range(0, 17);
         end
         if (wait_cycles > 0) begin
            rsp_tready <= 1'b0;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   initial begin : stimulus
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // absent band: every mask bit clear
      offer(make_cand(0, 0, 1000, 10, 10, 0, 0, 0), 1'b0);
      offer(make_cand(1, 0, 1000, 10, 10, 0, 1, 0), 1'b0);
      offer(make_cand(2, 0, 1000, 10, 10, 0, 1, 0), 1'b1);
      // load exactly at capacity still fits
      offer(make_cand(7, 1, 300, 100, 200, 0, 0, 0), 1'b1);
      // busy ties, boost floor, over capacity, wide sum, masked closing item
      offer(make_cand(0, 1, 1000, 100, 50, 0, 0, 0), 1'b0);
      offer(make_cand(1, 1, 1000, 100, 50, 0, 0, 0), 1'b0);
      offer(make_cand(2, 1, 1000, 0, 50, 400, 0, 0), 1'b0);
      offer(make_cand(3, 1, 69, 20, 50, 0, 0, 0), 1'b0);
      offer(make_cand(4, 1, 65535, 65535, 65535, 0, 0, 0), 1'b0);
      offer(make_cand(5, 1, 65535, 0, 0, 65535, 0, 0), 1'b0);
      offer(make_cand(6, 0, 1000, 0, 0, 0, 0, 0), 1'b1);
      // idle beats busy; depth first, then strictly lower wake
      offer(make_cand(0, 1, 1000, 5, 5, 0, 0, 0), 1'b0);
      offer(make_cand(1, 1, 1000, 10, 0, 0, 1, 3), 1'b0);
      offer(make_cand(2, 1, 1000, 500, 0, 0, 1, 1), 1'b0);
      offer(make_cand(3, 1, 1000, 500, 0, 0, 1, 1), 1'b0);
      offer(make_cand(4, 1, 1000, 499, 0, 0, 1, 1), 1'b0);
      offer(make_cand(5, 1, 800, 900, 0, 0, 1, 0), 1'b0);
      offer(make_cand(6, 1, 1000, 0, 0, 0, 1, 15), 1'b0);
      offer(make_cand(7, 1, 1000, 499, 0, 0, 1, 1), 1'b1);
      // all ones, then all zeros busy and idle
      offer(make_cand(7, 1, 65535, 65535, 65535, 65535, 1, 15), 1'b1);
      offer(make_cand(0, 1, 0, 0, 0, 0, 0, 0), 1'b1);
      offer(make_cand(0, 1, 0, 0, 0, 0, 1, 0), 1'b1);
      wait_drained();

      while (items_sent < ITEM_TARGET) begin
         steady = ($urandom_range(0, 7) == 0);
         if (!held_off && items_sent >= ITEM_TARGET / 2) begin
            // stall the pick side while one-item scans keep coming
            held_off = 1'b1;
            steady   = 1'b1;
            rsp_hold = 1'b1;
            repeat (48) offer(random_cand(3'($urandom_range(0, 7)), 16'd100, 16'd0), 1'b1);
            wait_drained();
         end
         random_scan();
         if ($urandom_range(0, 30) == 0) wait_drained();
      end
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("summary: %0d candidates in %0d scans; picks: %0d idle, %0d busy, %0d none",
               items_sent, scans_sent, idle_picks, busy_picks, empty_picks);
      $display("summary: one long pick-side stall, drained pauses and gapless stretches");
      if (mismatches == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/bcs_pkg.sv
hw/rtl/bcs_front.sv
hw/rtl/bcs_fifo.sv
hw/rtl/bcs_back.sv
hw/rtl/band_cpu_select.sv
hw/rtl/bcs_checker.sv
tb/bcs_checker.sv
tb/tb_top.sv
